// File: src/sfr_pkg.sv
package sfr_pkg;

    localparam int unsigned PADDR_W    = 5;
    localparam int unsigned PDATA_W    = 64;
    localparam int unsigned REPL_BYTES = 8;
    localparam int unsigned RIDX_W     = 3;

    localparam logic [1:0] REG_PATTERN  = 2'd0;
    localparam logic [1:0] REG_PLEN     = 2'd1;
    localparam logic [1:0] REG_REPL     = 2'd2;
    localparam logic [1:0] REG_RLEN     = 2'd3;

    localparam logic [7:0] NEWLINE_BYTE = 8'd10;
    localparam logic [3:0] REPL_MAX_LEN = 4'd8;

    typedef enum logic [1:0] {
        SEL_HELD = 2'd0,
        SEL_REPL = 2'd1,
        SEL_NL   = 2'd2
    } t_out_sel;

    typedef struct packed {
        logic [63:0] search_pattern;
        logic [3:0]  pattern_length;
        logic [63:0] replacement_text;
        logic [3:0]  replacement_length;
        logic        clear_window;
    } t_cfg;

    typedef struct packed {
        logic     load;
        logic     shift;
        logic     repl_step;
        logic     clear_count;
        t_out_sel sel;
    } t_dp_cmd;

    typedef struct packed {
        logic prefix;
        logic full;
        logic shift_last;
        logic count_zero;
        logic repl_last;
        logic repl_empty;
    } t_dp_sts;

endpackage

// File: src/sfr_in_if.sv
interface sfr_in_if;
    logic       valid;
    logic       ready;
    logic       op;
    logic [7:0] char_byte;

    modport source (output valid, output op, output char_byte, input ready);
    modport sink (input valid, input op, input char_byte, output ready);
endinterface

// File: src/sfr_out_if.sv
interface sfr_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last_of_run;

    modport source (output valid, output out_byte, output last_of_run, input ready);
    modport sink (input valid, input out_byte, input last_of_run, output ready);
endinterface

// File: src/sfr_cfg.sv
module sfr_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [sfr_pkg::PADDR_W-1:0]   paddr,
    input  logic [sfr_pkg::PDATA_W-1:0]   pwdata,
    output logic [sfr_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready,
    output sfr_pkg::t_cfg                 o_cfg
);

    logic [63:0] r_pattern;
    logic [3:0]  r_plen;
    logic [63:0] r_repl;
    logic [3:0]  r_rlen;
    logic        clr_win;
    logic        wr_en;
    logic [1:0]  reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[4:3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern <= '0;
            r_plen    <= 4'd1;
            r_repl    <= '0;
            r_rlen    <= '0;
        end else begin
            if (wr_en) begin
                unique case (reg_idx)
                    sfr_pkg::REG_PATTERN: r_pattern <= pwdata;
                    sfr_pkg::REG_PLEN:    r_plen    <= pwdata[3:0];
                    sfr_pkg::REG_REPL:    r_repl    <= pwdata;
                    sfr_pkg::REG_RLEN:    r_rlen    <= pwdata[3:0];
                    default: ;
                endcase
            end
        end
    end

    always_comb begin
        unique case (reg_idx)
            sfr_pkg::REG_PATTERN: prdata = r_pattern;
            sfr_pkg::REG_PLEN:    prdata = {60'd0, r_plen};
            sfr_pkg::REG_REPL:    prdata = r_repl;
            sfr_pkg::REG_RLEN:    prdata = {60'd0, r_rlen};
            default:              prdata = '0;
        endcase
    end

    // A write to the pattern or its length empties the window at the same edge,
    // so a beat taken straight after the write starts from an empty window.
    assign clr_win = wr_en && ((reg_idx == sfr_pkg::REG_PATTERN) ||
                               (reg_idx == sfr_pkg::REG_PLEN));

    assign o_cfg.search_pattern     = r_pattern;
    assign o_cfg.pattern_length     = r_plen;
    assign o_cfg.replacement_text   = r_repl;
    assign o_cfg.replacement_length = r_rlen;
    assign o_cfg.clear_window       = clr_win;

endmodule

// File: src/sfr_dp.sv
module sfr_dp #(
    parameter int unsigned MAX_PATTERN_BYTES = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  sfr_pkg::t_cfg     i_cfg,
    input  sfr_pkg::t_dp_cmd  i_cmd,
    input  logic [7:0]        i_char,
    output sfr_pkg::t_dp_sts  o_sts,
    output logic [7:0]        o_byte
);

    localparam int unsigned CW = $clog2(MAX_PATTERN_BYTES + 1);
    localparam int unsigned IW = (MAX_PATTERN_BYTES > 1) ? $clog2(MAX_PATTERN_BYTES) : 1;

    logic [7:0]                       r_win [MAX_PATTERN_BYTES];
    logic [CW-1:0]                    r_count;
    logic [CW-1:0]                    n_count;
    logic [sfr_pkg::RIDX_W-1:0]       r_ridx;
    logic [sfr_pkg::RIDX_W-1:0]       n_ridx;
    logic [CW-1:0]                    plen_eff;
    logic [3:0]                       rlen_eff;
    logic [MAX_PATTERN_BYTES-1:0]     match;
    logic [MAX_PATTERN_BYTES-1:0]     smatch;
    logic [7:0]                       repl_byte;

    always_comb begin
        if (i_cfg.pattern_length == 4'd0) begin
            plen_eff = CW'(1);
        end else if (i_cfg.pattern_length > 4'(MAX_PATTERN_BYTES)) begin
            plen_eff = CW'(MAX_PATTERN_BYTES);
        end else begin
            plen_eff = CW'(i_cfg.pattern_length);
        end
        if (i_cfg.replacement_length > sfr_pkg::REPL_MAX_LEN) begin
            rlen_eff = sfr_pkg::REPL_MAX_LEN;
        end else begin
            rlen_eff = i_cfg.replacement_length;
        end
    end

    // Prefix test of the window as held, and of the window as it would be
    // after its oldest byte is released.
    always_comb begin
        match  = '1;
        smatch = '1;
        for (int i = 0; i < MAX_PATTERN_BYTES; i++) begin
            if (CW'(i) < r_count) begin
                match[i] = (r_win[i] == i_cfg.search_pattern[8*i +: 8]);
            end
        end
        for (int i = 0; i < MAX_PATTERN_BYTES - 1; i++) begin
            if (CW'(i + 1) < r_count) begin
                smatch[i] = (r_win[i+1] == i_cfg.search_pattern[8*i +: 8]);
            end
        end
    end

    assign repl_byte = i_cfg.replacement_text[8*r_ridx +: 8];

    assign o_sts.prefix     = &match;
    assign o_sts.full       = (r_count == plen_eff);
    assign o_sts.shift_last = (r_count == CW'(1)) || (&smatch);
    assign o_sts.count_zero = (r_count == '0);
    assign o_sts.repl_last  = ((4'(r_ridx) + 4'd1) == rlen_eff);
    assign o_sts.repl_empty = (rlen_eff == 4'd0);

    always_comb begin
        unique case (i_cmd.sel)
            sfr_pkg::SEL_HELD: o_byte = r_win[0];
            sfr_pkg::SEL_REPL: o_byte = repl_byte;
            sfr_pkg::SEL_NL:   o_byte = sfr_pkg::NEWLINE_BYTE;
            default:           o_byte = sfr_pkg::NEWLINE_BYTE;
        endcase
    end

    always_comb begin
        n_count = r_count;
        n_ridx  = r_ridx;
        if (i_cmd.load) begin
            n_count = r_count + CW'(1);
        end
        if (i_cmd.shift) begin
            n_count = r_count - CW'(1);
        end
        if (i_cmd.repl_step) begin
            n_ridx = o_sts.repl_last ? '0 : r_ridx + sfr_pkg::RIDX_W'(1);
        end
        if (i_cmd.clear_count || i_cfg.clear_window) begin
            n_count = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_ridx  <= '0;
        end else begin
            r_count <= n_count;
            r_ridx  <= n_ridx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_win[r_count[IW-1:0]] <= i_char;
        end else if (i_cmd.shift) begin
            for (int i = 0; i < MAX_PATTERN_BYTES - 1; i++) begin
                r_win[i] <= r_win[i+1];
            end
        end
    end

endmodule

// File: src/sfr_ctrl.sv
module sfr_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_op,
    input  logic              i_out_ready,
    input  sfr_pkg::t_dp_sts  i_sts,
    output logic              o_in_ready,
    output logic              o_out_valid,
    output logic              o_out_last,
    output sfr_pkg::t_dp_cmd  o_cmd
);

    typedef enum logic [4:0] {
        ST_IDLE    = 5'b00001,
        ST_CHECK   = 5'b00010,
        ST_RELEASE = 5'b00100,
        ST_REPL    = 5'b01000,
        ST_FLUSH   = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   out_beat;

    assign out_beat = o_out_valid && i_out_ready;

    always_comb begin
        n_state           = r_state;
        o_in_ready        = 1'b0;
        o_out_valid       = 1'b0;
        o_out_last        = 1'b0;
        o_cmd.load        = 1'b0;
        o_cmd.shift       = 1'b0;
        o_cmd.repl_step   = 1'b0;
        o_cmd.clear_count = 1'b0;
        o_cmd.sel         = sfr_pkg::SEL_HELD;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_in_op) begin
                        n_state = ST_FLUSH;
                    end else begin
                        o_cmd.load = 1'b1;
                        n_state    = ST_CHECK;
                    end
                end
            end
            ST_CHECK: begin
                if (!i_sts.prefix) begin
                    n_state = ST_RELEASE;
                end else if (i_sts.full && !i_sts.repl_empty) begin
                    n_state = ST_REPL;
                end else begin
                    o_cmd.clear_count = i_sts.full;
                    n_state           = ST_IDLE;
                end
            end
            ST_RELEASE: begin
                // Once the shortened window is a prefix again, this beat ends
                // the run; a shortened window can never be a full match.
                o_out_valid = 1'b1;
                o_out_last  = i_sts.shift_last;
                if (out_beat) begin
                    o_cmd.shift = 1'b1;
                    if (i_sts.shift_last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_REPL: begin
                o_out_valid = 1'b1;
                o_out_last  = i_sts.repl_last;
                o_cmd.sel   = sfr_pkg::SEL_REPL;
                if (out_beat) begin
                    o_cmd.repl_step = 1'b1;
                    if (i_sts.repl_last) begin
                        o_cmd.clear_count = 1'b1;
                        n_state           = ST_IDLE;
                    end
                end
            end
            ST_FLUSH: begin
                o_out_valid = 1'b1;
                o_out_last  = i_sts.count_zero;
                o_cmd.sel   = i_sts.count_zero ? sfr_pkg::SEL_NL : sfr_pkg::SEL_HELD;
                if (out_beat) begin
                    if (i_sts.count_zero) begin
                        n_state = ST_IDLE;
                    end else begin
                        o_cmd.shift = 1'b1;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// File: src/stream_find_and_replace.sv
// A text beat is checked in the cycle after it is taken and an end-of-line beat
// starts its output in the next cycle; output bytes follow at one beat per cycle
// while the receiver holds ready high. One item at a time: no new beat is taken
// until the last one has been checked and its output, if any, is done.
// Reset is synchronous and active low: the window empties and the registers
// return to pattern 0, pattern length 1, replacement 0, replacement length 0.
module stream_find_and_replace #(
    parameter int unsigned MAX_PATTERN_BYTES = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    sfr_in_if.sink                        i_in,
    sfr_out_if.source                     o_out,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [sfr_pkg::PADDR_W-1:0]   paddr,
    input  logic [sfr_pkg::PDATA_W-1:0]   pwdata,
    output logic [sfr_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready
);

    sfr_pkg::t_cfg    cfg;
    sfr_pkg::t_dp_cmd cmd;
    sfr_pkg::t_dp_sts sts;

    sfr_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    sfr_dp #(
        .MAX_PATTERN_BYTES (MAX_PATTERN_BYTES)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_cmd   (cmd),
        .i_char  (i_in.char_byte),
        .o_sts   (sts),
        .o_byte  (o_out.out_byte)
    );

    sfr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_in_op     (i_in.op),
        .i_out_ready (o_out.ready),
        .i_sts       (sts),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .o_out_last  (o_out.last_of_run),
        .o_cmd       (cmd)
    );

endmodule

// File: verif/sfr_tb_pkg.sv
package sfr_tb_pkg;

    // Codes of the op field of an input beat.
    localparam logic OP_TEXT = 1'b0;
    localparam logic OP_EOL  = 1'b1;

endpackage

// File: verif/stream_find_and_replace_checker.sv
module stream_find_and_replace_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    sfr_in_if                           in_mon,
    sfr_out_if                          out_mon,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic                        pready,
    input  logic [sfr_pkg::PADDR_W-1:0] paddr,
    input  logic [sfr_pkg::PDATA_W-1:0] pwdata,
    output int                          fail_count,
    output int                          pending_beats
);
    import sfr_pkg::*;
    import sfr_tb_pkg::*;

    localparam int unsigned WIN_BYTES  = 8;
    localparam int unsigned MAX_PRINTS = 100;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } text_beat_t;

    logic [63:0] cfg_pattern;
    logic [3:0]  cfg_plen;
    logic [63:0] cfg_repl;
    logic [3:0]  cfg_rlen;
    logic [7:0]  win_bytes [WIN_BYTES];
    int unsigned win_fill;

    text_beat_t  due_beats [$];
    text_beat_t  want;

    task automatic flag_mismatch(input string what, input int got, input int wanted);
        if (fail_count < MAX_PRINTS) begin
            $display("mismatch at %0t: %s, got %0h, expected %0h", $realtime, what, got, wanted);
        end
        fail_count++;
    endtask

    // Works out the bytes that one input beat releases and queues them in order.
    task automatic replace_step(input logic op, input logic [7:0] ch);
        text_beat_t  run [$];
        int unsigned plen;
        int unsigned rlen;
        bit          is_prefix;

        plen = (cfg_plen == 0) ? 1 : (cfg_plen > WIN_BYTES) ? WIN_BYTES : cfg_plen;
        rlen = (cfg_rlen > REPL_MAX_LEN) ? REPL_MAX_LEN : cfg_rlen;
        if (win_fill >= plen) win_fill = plen - 1;

        if (op == OP_EOL) begin
            for (int i = 0; i < win_fill; i++) run.push_back('{win_bytes[i], 1'b0});
            run.push_back('{NEWLINE_BYTE, 1'b0});
            win_fill = 0;
        end else begin
            win_bytes[win_fill] = ch;
            win_fill++;
            while (win_fill > 0) begin
                is_prefix = 1'b1;
                for (int i = 0; i < win_fill; i++) begin
                    if (win_bytes[i] != cfg_pattern[8*i +: 8]) is_prefix = 1'b0;
                end
                if (is_prefix) begin
                    if (win_fill == plen) begin
                        for (int i = 0; i < rlen; i++) run.push_back('{cfg_repl[8*i +: 8], 1'b0});
                        win_fill = 0;
                    end
                    break;
                end
                // The window no longer leads into the pattern: release its oldest byte.
                run.push_back('{win_bytes[0], 1'b0});
                for (int i = 1; i < WIN_BYTES; i++) win_bytes[i-1] = win_bytes[i];
                win_fill--;
            end
        end

        if (run.size() > 0) run[run.size()-1].last = 1'b1;
        foreach (run[i]) due_beats.push_back(run[i]);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg_pattern = '0;
            cfg_plen    = 4'd1;
            cfg_repl    = '0;
            cfg_rlen    = 4'd0;
            for (int i = 0; i < WIN_BYTES; i++) win_bytes[i] = '0;
            win_fill = 0;
            due_beats.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[PADDR_W-1:3])
                    REG_PATTERN: begin
                        cfg_pattern = pwdata;
                        win_fill    = 0;
                    end
                    REG_PLEN: begin
                        cfg_plen = pwdata[3:0];
                        win_fill = 0;
                    end
                    REG_REPL: cfg_repl = pwdata;
                    REG_RLEN: cfg_rlen = pwdata[3:0];
                    default: ;
                endcase
            end

            if (in_mon.valid && in_mon.ready) replace_step(in_mon.op, in_mon.char_byte);

            if (out_mon.valid && out_mon.ready) begin
                if (due_beats.size() == 0) begin
                    flag_mismatch("output beat with nothing due", out_mon.out_byte, 0);
                end else begin
                    want = due_beats.pop_front();
                    if (out_mon.out_byte !== want.data)
                        flag_mismatch("out_byte", out_mon.out_byte, want.data);
                    if (out_mon.last_of_run !== want.last)
                        flag_mismatch("last_of_run", out_mon.last_of_run, want.last);
                end
            end
        end
        pending_beats = due_beats.size();
    end

endmodule

// File: verif/stream_find_and_replace_tb.sv
module stream_find_and_replace_tb;
    import sfr_pkg::*;
    import sfr_tb_pkg::*;

    localparam int unsigned IDLE_LIMIT   = 2000;
    localparam int unsigned LONG_HOLD    = 200;
    localparam int unsigned DRAIN_CYCLES = 12;
    localparam int unsigned PHASES       = 6;
    localparam int unsigned PHASE_BEATS  = 50;
    localparam int unsigned MAX_PAT      = 8;

    logic               i_clk;
    logic               i_rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    int                 fail_count;
    int                 pending_beats;
    int unsigned        beats_out    = 0;
    int unsigned        quiet_cycles = 0;
    bit                 calm         = 1'b0;
    logic [7:0]         pat_bytes [MAX_PAT];
    int unsigned        pat_n        = 1;

    sfr_in_if  in_if ();
    sfr_out_if out_if ();

    stream_find_and_replace dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    stream_find_and_replace_checker u_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .in_mon        (in_if),
        .out_mon       (out_if),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .pready        (pready),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .fail_count    (fail_count),
        .pending_beats (pending_beats)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send_beat(input logic op, input logic [7:0] b);
        int unsigned gap;
        gap = pick_gap();
        if (gap != 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid     <= 1'b1;
        in_if.op        <= op;
        in_if.char_byte <= b;
        do @(posedge i_clk); while (!in_if.ready);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_beat(OP_TEXT, s[i]);
    endtask

    // Lets every due beat arrive, then gives the block time to finish a beat that
    // released nothing, so that a register write finds it idle.
    task automatic settle();
        in_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_beats != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic [1:0] idx, input logic [63:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic load_pattern(input logic [63:0] word, input logic [63:0] len_word);
        apb_write(REG_PATTERN, word);
        apb_write(REG_PLEN, len_word);
        for (int i = 0; i < MAX_PAT; i++) pat_bytes[i] = word[8*i +: 8];
        pat_n = (len_word[3:0] == 0) ? 1 : (len_word[3:0] > MAX_PAT) ? MAX_PAT : len_word[3:0];
    endtask

    task automatic load_replacement(input logic [63:0] word, input logic [63:0] len_word);
        apb_write(REG_REPL, word);
        apb_write(REG_RLEN, len_word);
    endtask

    always @(posedge i_clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) || (psel && penable))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (out_if.valid && out_if.ready) beats_out <= beats_out + 1;
    end

    initial begin : watchdog
        wait (quiet_cycles >= IDLE_LIMIT);
        $display("status: fail");
        $finish;
    end

    initial begin : receiver
        int unsigned span;
        bit          held_long;
        held_long = 1'b0;
        out_if.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (!held_long && beats_out >= 60) begin
                // One long hold-off while the sender keeps offering, so the block
                // fills up and has to stall its input.
                held_long = 1'b1;
                out_if.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end
            if (calm || $urandom_range(0, 2) != 0) begin
                out_if.ready <= 1'b1;
                span = $urandom_range(1, 16);
            end else begin
                out_if.ready <= 1'b0;
                span = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
            end
            repeat (span) @(posedge i_clk);
        end
    end

    initial begin : stimulus
        int unsigned sent;
        int unsigned k;
        int unsigned m;
        logic [63:0] word;
        logic [63:0] len_word;
        logic [7:0]  sym0;
        logic [7:0]  sym1;
        bit          paired;

        i_rst_n         <= 1'b0;
        psel            <= 1'b0;
        penable         <= 1'b0;
        pwrite          <= 1'b0;
        paddr           <= '0;
        pwdata          <= '0;
        in_if.valid     <= 1'b0;
        in_if.op        <= OP_TEXT;
        in_if.char_byte <= '0;
        for (int i = 0; i < MAX_PAT; i++) pat_bytes[i] = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: the pattern is the single byte zero, the replacement is empty,
        // so a zero byte disappears while a newline byte passes as ordinary text.
        send_beat(OP_TEXT, 8'h00);
        send_beat(OP_TEXT, 8'hFF);
        send_beat(OP_TEXT, NEWLINE_BYTE);
        send_beat(OP_EOL, 8'hA5);
        settle();

        load_pattern(64'h0000_0000_0063_6261, 64'd3);
        load_replacement(64'h0000_0000_0000_5958, 64'd2);
        send_text("aabc");
        send_text("ab");
        send_beat(OP_EOL, 8'h00);

        // A new replacement applies to the bytes already held.
        send_text("ab");
        settle();
        load_replacement('1, 64'hF);
        send_text("c");

        // Rewriting the pattern drops the held bytes unseen.
        send_text("ab");
        settle();
        load_pattern(64'h0000_0000_0063_6261, 64'hFFFF_FFFF_FFFF_FFF3);
        send_text("c");

        // A length of zero counts as one; a length above eight counts as eight.
        settle();
        load_pattern('1, 64'd0);
        load_replacement('0, 64'd0);
        send_beat(OP_TEXT, 8'hFF);
        send_beat(OP_TEXT, 8'h00);
        settle();
        load_pattern('1, 64'hF);
        load_replacement('0, 64'd8);
        repeat (8) send_beat(OP_TEXT, 8'hFF);

        for (int ph = 0; ph < PHASES; ph++) begin
            settle();
            calm   = (ph % 3 == 2);
            paired = ($urandom_range(0, 2) != 0);
            sym0   = 8'($urandom);
            sym1   = 8'($urandom);
            for (int i = 0; i < MAX_PAT; i++)
                word[8*i +: 8] = paired ? ($urandom_range(0, 1) ? sym0 : sym1) : 8'($urandom);
            len_word = {$urandom, $urandom};
            len_word[3:0] = 4'($urandom_range(1, MAX_PAT));
            if (len_word[3:0] == 1 && $urandom_range(0, 1)) len_word[3:0] = 4'd0;
            if (len_word[3:0] == MAX_PAT && $urandom_range(0, 1))
                len_word[3:0] = 4'($urandom_range(9, 15));
            load_pattern(word, len_word);
            len_word = {$urandom, $urandom};
            load_replacement({$urandom, $urandom}, len_word);

            sent = 0;
            while (sent < PHASE_BEATS) begin
                k = $urandom_range(0, 99);
                if (k < 40) begin
                    for (int i = 0; i < pat_n; i++) send_beat(OP_TEXT, pat_bytes[i]);
                    sent += pat_n;
                end else if (k < 65) begin
                    // A prefix of the pattern followed by a byte that may break it off.
                    m = $urandom_range(0, pat_n - 1);
                    for (int i = 0; i < m; i++) send_beat(OP_TEXT, pat_bytes[i]);
                    send_beat(OP_TEXT, $urandom_range(0, 1) ?
                              pat_bytes[$urandom_range(0, pat_n - 1)] : 8'($urandom));
                    sent += m + 1;
                end else if (k < 88) begin
                    send_beat(OP_TEXT, 8'($urandom));
                    sent++;
                end else begin
                    send_beat(OP_EOL, 8'($urandom));
                    sent++;
                end
            end
        end

        settle();
        if (fail_count == 0 && pending_beats == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
